FILE: rtl/wsm_pkg.sv
// Package for the WAV byte stream to mono sample decoder.
// Holds the item types, parser phase enum, result/error codes and the float to Q1.31 helper.
// No dependencies.
package wsm_pkg;

   localparam int FifoDepth = 4;
   localparam int PtrBits   = 2;

   localparam logic [31:0] TAG_RIFF  = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE  = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT   = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA  = 32'h6174_6164;
   localparam logic [15:0] FMT_PCM   = 16'h0001;
   localparam logic [15:0] FMT_FLOAT = 16'h0003;

   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_INFO   = 2'd1;
   localparam logic [1:0] KIND_DONE   = 2'd2;
   localparam logic [1:0] KIND_ERROR  = 2'd3;

   localparam logic [3:0] ERR_RIFF      = 4'd0;
   localparam logic [3:0] ERR_WAVE      = 4'd1;
   localparam logic [3:0] ERR_SHORT_FMT = 4'd2;
   localparam logic [3:0] ERR_FORMAT    = 4'd3;
   localparam logic [3:0] ERR_CHANNELS  = 4'd4;
   localparam logic [3:0] ERR_DEPTH     = 4'd5;
   localparam logic [3:0] ERR_NO_FMT    = 4'd6;
   localparam logic [3:0] ERR_NO_DATA   = 4'd7;
   localparam logic [3:0] ERR_TRUNC     = 4'd8;

   typedef enum logic [3:0] {
      PH_RIFF, PH_RSIZE, PH_WAVE, PH_CHDR, PH_FMT,
      PH_DATA, PH_SKIP, PH_PAD, PH_DONE, PH_DEAD
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [1:0]         result_kind;
      logic signed [31:0] mono_sample;
      logic [31:0]        rate_hz;
      logic [1:0]         channel_count_out;
      logic [5:0]         sample_width_bits;
      logic               is_float;
      logic [3:0]         error_code;
      logic               last_of_run;
   } rsp_type;

   // IEEE single to Q1.31: scale by 2^31, truncate toward zero, saturate, NaN to zero.
   function automatic logic [31:0] float_to_q31(input logic [31:0] f);
      logic [7:0]  ex;
      logic [23:0] m;
      logic [31:0] mag;
      logic [7:0]  rsh;
      ex  = f[30:23];
      m   = {1'b1, f[22:0]};
      mag = '0;
      rsh = 8'd119 - ex;
      if (ex == 8'hFF && f[22:0] != 23'd0) begin
         return 32'd0;
      end
      if (ex == 8'd0) begin
         return 32'd0;
      end
      if (ex >= 8'd127) begin
         return f[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      if (ex >= 8'd119) begin
         mag = {8'd0, m} << (ex - 8'd119);
      end else if (rsh >= 8'd24) begin
         mag = 32'd0;
      end else begin
         mag = {8'd0, m} >> rsh;
      end
      return f[31] ? (32'd0 - mag) : mag;
   endfunction

endpackage

FILE: rtl/wav_stream_to_mono_samples.sv
// Top level of the WAV byte stream to mono Q1.31 sample decoder.
// Contains the input register, the RIFF/WAVE parser and a small result queue.
// Depends on wsm_pkg.
//
// Usage: one byte of a WAV file enters per item on the req_ channel, with
// end_of_stream set on the file's final byte. The block checks the RIFF and
// WAVE tags, walks chunks, validates fmt, and on the rsp_ channel returns a
// format-info item, then one mono sample item per frame (stereo averaged
// with floor), and at end of stream a finished or error item. An error code
// item is sent once; later bytes of that file produce nothing.
// An accepted byte is parsed while it sits in the input register; its
// results are written into the result queue and presented at rsp_ from there.
// Throughput: one byte per cycle while req_stall is low. A byte yields at
// most two result items; the parser advances only while the four-entry
// result queue has two free places, so the queue drain rate at rsp_ is what
// limits a sustained stream.
// Reset clears the parser to expect a RIFF tag and empties the queue. When
// the receiver holds rsp_stall, queued items stay put and req_stall rises
// once the queue cannot take another byte's worst case. After end of
// stream the parser returns to its reset state, ready for the next file.
module wav_stream_to_mono_samples
   import wsm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Input register.
   logic    in_vld_ff, in_vld_in;
   req_type in_ff;
   logic    adv;

   // Parser state.
   phase_type   phase_ff, phase_in;
   logic [4:0]  idx_ff, idx_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] rem_ff, rem_in;
   logic        flt_ff, flt_in;
   logic [1:0]  ch_ff, ch_in;
   logic [5:0]  bits_ff, bits_in;
   logic [31:0] rate_ff, rate_in;
   logic [31:0] asm_ff, asm_in;
   logic [31:0] left_ff, left_in;
   logic        have_left_ff, have_left_in;
   logic        fmt_seen_ff, fmt_seen_in;
   logic        pad_ff, pad_in;

   // Results of the current byte.
   rsp_type     res0, res1;
   logic [1:0]  nres;

   // Result queue.
   rsp_type             q_mem [FifoDepth];
   logic [PtrBits-1:0]  rd_ff, wr_ff;
   logic [PtrBits:0]    cnt_ff;
   logic                pop;

   assign adv       = in_vld_ff && (cnt_ff <= (PtrBits + 1)'(FifoDepth - 2));
   assign req_stall = in_vld_ff && !adv;
   assign in_vld_in = req_valid || (in_vld_ff && !adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
      if (!req_stall) begin
         in_ff <= req_data;
      end
   end

   // Parser: next state and the result items for one byte.
   always_comb begin
      logic [7:0]  b;
      logic [1:0]  bsel;
      logic [31:0] bshift;
      logic [15:0] code, chan, bits16;
      logic [2:0]  bps;
      logic [31:0] v;
      logic [32:0] sum;
      logic [4:0]  idx_nx;
      logic        fail;
      logic [3:0]  ecode;
      logic        emit;
      rsp_type     r;

      b      = in_ff.data_byte;
      bsel   = idx_ff[1:0];
      bshift = {24'd0, b} << {bsel, 3'b000};
      code   = tag_ff[15:0];
      chan   = tag_ff[31:16];
      bits16 = {asm_ff[15:8] | b, asm_ff[7:0]};
      bps    = bits_ff[5:3];
      v      = '0;
      sum    = '0;
      idx_nx = idx_ff + 5'd1;
      fail   = 1'b0;
      ecode  = ERR_RIFF;
      emit   = 1'b0;
      r      = '0;

      phase_in     = phase_ff;
      idx_in       = idx_ff;
      tag_in       = tag_ff;
      rem_in       = rem_ff;
      flt_in       = flt_ff;
      ch_in        = ch_ff;
      bits_in      = bits_ff;
      rate_in      = rate_ff;
      asm_in       = asm_ff;
      left_in      = left_ff;
      have_left_in = have_left_ff;
      fmt_seen_in  = fmt_seen_ff;
      pad_in       = pad_ff;
      res0         = '0;
      res1         = '0;
      nres         = 2'd0;

      case (phase_ff)
         PH_RIFF, PH_WAVE: begin
            tag_in = (idx_ff == 5'd0) ? {24'd0, b} : (tag_ff | bshift);
            if (idx_ff < 5'd3) begin
               idx_in = idx_nx;
            end else begin
               idx_in = '0;
               if (phase_ff == PH_RIFF) begin
                  if (tag_in != TAG_RIFF) begin
                     fail = 1'b1; ecode = ERR_RIFF;
                  end else begin
                     phase_in = PH_RSIZE;
                  end
               end else begin
                  if (tag_in != TAG_WAVE) begin
                     fail = 1'b1; ecode = ERR_WAVE;
                  end else begin
                     phase_in = PH_CHDR;
                  end
               end
            end
         end
         PH_RSIZE: begin
            if (idx_ff < 5'd3) begin
               idx_in = idx_nx;
            end else begin
               idx_in   = '0;
               phase_in = PH_WAVE;
            end
         end
         PH_CHDR: begin
            if (idx_ff < 5'd4) begin
               tag_in = (idx_ff == 5'd0) ? {24'd0, b} : (tag_ff | bshift);
            end else begin
               rem_in = (idx_ff == 5'd4) ? {24'd0, b} : (rem_ff | bshift);
            end
            if (idx_ff < 5'd7) begin
               idx_in = idx_nx;
            end else begin
               idx_in = '0;
               pad_in = rem_in[0];
               if (tag_in == TAG_FMT) begin
                  if (rem_in < 32'd16) begin
                     fail = 1'b1; ecode = ERR_SHORT_FMT;
                  end else begin
                     phase_in = PH_FMT;
                  end
               end else if (tag_in == TAG_DATA) begin
                  if (!fmt_seen_ff) begin
                     fail = 1'b1; ecode = ERR_NO_FMT;
                  end else begin
                     have_left_in = 1'b0;
                     asm_in       = '0;
                     phase_in     = (rem_in == 32'd0) ? PH_DONE : PH_DATA;
                  end
               end else if (rem_in == 32'd0) begin
                  phase_in = rem_in[0] ? PH_PAD : PH_CHDR;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
         end
         PH_FMT: begin
            if (idx_ff < 5'd4) begin
               tag_in = (idx_ff == 5'd0) ? {24'd0, b} : (tag_ff | bshift);
            end else if (idx_ff < 5'd8) begin
               rate_in = (idx_ff == 5'd4) ? {24'd0, b} : (rate_ff | bshift);
            end else if (idx_ff == 5'd14) begin
               asm_in = {24'd0, b};
            end else if (idx_ff == 5'd15) begin
               asm_in = '0;
               if (code != FMT_PCM && code != FMT_FLOAT) begin
                  fail = 1'b1; ecode = ERR_FORMAT;
               end else if (chan != 16'd1 && chan != 16'd2) begin
                  fail = 1'b1; ecode = ERR_CHANNELS;
               end else if ((bits16 != 16'd16 && bits16 != 16'd24 && bits16 != 16'd32) ||
                            (code == FMT_FLOAT && bits16 != 16'd32)) begin
                  fail = 1'b1; ecode = ERR_DEPTH;
               end else begin
                  ch_in       = chan[1:0];
                  bits_in     = bits16[5:0];
                  flt_in      = (code == FMT_FLOAT);
                  fmt_seen_in = 1'b1;
                  emit        = 1'b1;
                  r.result_kind       = KIND_INFO;
                  r.rate_hz           = rate_ff;
                  r.channel_count_out = chan[1:0];
                  r.sample_width_bits = bits16[5:0];
                  r.is_float          = (code == FMT_FLOAT);
               end
            end
            if (!fail) begin
               if (idx_ff < 5'd16) begin
                  idx_in = idx_nx;
               end
               rem_in = rem_ff - 32'd1;
               if (rem_in == 32'd0) begin
                  idx_in   = '0;
                  phase_in = pad_ff ? PH_PAD : PH_CHDR;
               end
            end
         end
         PH_DATA: begin
            asm_in = asm_ff | bshift;
            idx_in = idx_nx;
            if (idx_nx >= {2'b00, bps}) begin
               if (flt_ff) begin
                  v = float_to_q31(asm_in);
               end else if (bits_ff == 6'd16) begin
                  v = asm_in << 16;
               end else if (bits_ff == 6'd24) begin
                  v = asm_in << 8;
               end else begin
                  v = asm_in;
               end
               idx_in = '0;
               asm_in = '0;
               if (ch_ff != 2'd2) begin
                  emit          = 1'b1;
                  r.mono_sample = v;
               end else if (!have_left_ff) begin
                  left_in      = v;
                  have_left_in = 1'b1;
               end else begin
                  sum           = {left_ff[31], left_ff} + {v[31], v};
                  have_left_in  = 1'b0;
                  emit          = 1'b1;
                  r.mono_sample = sum[32:1];
               end
            end
            rem_in = rem_ff - 32'd1;
            if (rem_in == 32'd0) begin
               phase_in = PH_DONE;
               idx_in   = '0;
            end
         end
         PH_SKIP: begin
            rem_in = rem_ff - 32'd1;
            if (rem_in == 32'd0) begin
               idx_in   = '0;
               phase_in = pad_ff ? PH_PAD : PH_CHDR;
            end
         end
         PH_PAD: begin
            pad_in   = 1'b0;
            idx_in   = '0;
            phase_in = PH_CHDR;
         end
         default: begin
         end
      endcase

      if (fail) begin
         emit         = 1'b1;
         r            = '0;
         r.result_kind = KIND_ERROR;
         r.error_code  = ecode;
         phase_in      = PH_DEAD;
      end
      if (emit) begin
         res0 = r;
         nres = 2'd1;
      end

      if (in_ff.end_of_stream) begin
         r    = '0;
         emit = 1'b1;
         r.result_kind = KIND_ERROR;
         case (phase_in)
            PH_DEAD:  emit = 1'b0;
            PH_DONE:  r.result_kind = KIND_DONE;
            PH_RIFF:  r.error_code = ERR_RIFF;
            PH_RSIZE: r.error_code = ERR_TRUNC;
            PH_WAVE:  r.error_code = ERR_WAVE;
            PH_DATA:  r.error_code = ERR_TRUNC;
            PH_FMT: begin
               if (idx_in < 5'd16) begin
                  r.error_code = ERR_TRUNC;
               end else begin
                  r.error_code = fmt_seen_in ? ERR_NO_DATA : ERR_NO_FMT;
               end
            end
            default:  r.error_code = fmt_seen_in ? ERR_NO_DATA : ERR_NO_FMT;
         endcase
         if (emit) begin
            if (nres == 2'd0) begin
               res0 = r;
            end else begin
               res1 = r;
            end
            nres = nres + 2'd1;
         end
         phase_in     = PH_RIFF;
         idx_in       = '0;
         tag_in       = '0;
         rem_in       = '0;
         flt_in       = 1'b0;
         ch_in        = '0;
         bits_in      = '0;
         rate_in      = '0;
         asm_in       = '0;
         left_in      = '0;
         have_left_in = 1'b0;
         fmt_seen_in  = 1'b0;
         pad_in       = 1'b0;
      end

      if (nres == 2'd2) begin
         res1.last_of_run = 1'b1;
      end else begin
         res0.last_of_run = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_RIFF;
         idx_ff       <= '0;
         tag_ff       <= '0;
         rem_ff       <= '0;
         flt_ff       <= 1'b0;
         ch_ff        <= '0;
         bits_ff      <= '0;
         rate_ff      <= '0;
         asm_ff       <= '0;
         left_ff      <= '0;
         have_left_ff <= 1'b0;
         fmt_seen_ff  <= 1'b0;
         pad_ff       <= 1'b0;
      end else if (adv) begin
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         tag_ff       <= tag_in;
         rem_ff       <= rem_in;
         flt_ff       <= flt_in;
         ch_ff        <= ch_in;
         bits_ff      <= bits_in;
         rate_ff      <= rate_in;
         asm_ff       <= asm_in;
         left_ff      <= left_in;
         have_left_ff <= have_left_in;
         fmt_seen_ff  <= fmt_seen_in;
         pad_ff       <= pad_in;
      end
   end

   // Result queue: up to two pushes and one pop per cycle.
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data  = q_mem[rd_ff];
   assign pop       = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (adv && nres != 2'd0) begin
         q_mem[wr_ff] <= res0;
      end
      if (adv && nres == 2'd2) begin
         q_mem[wr_ff + PtrBits'(1)] <= res1;
      end
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (pop) begin
            rd_ff <= rd_ff + PtrBits'(1);
         end
         if (adv) begin
            wr_ff <= wr_ff + PtrBits'(nres);
         end
         cnt_ff <= cnt_ff + (adv ? (PtrBits + 1)'(nres) : '0) - (PtrBits + 1)'(pop);
      end
   end

   // The queue never overfills.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PtrBits + 1)'(FifoDepth))
      else $error("result queue overflow");

   // Upstream is only held off by a waiting byte.
   a_stall_has_byte: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_vld_ff)
      else $error("stall without a held byte");

   // The end of a file always returns the parser to the RIFF tag.
   a_eos_resets: assert property (@(posedge clock) disable iff (reset)
      (adv && in_ff.end_of_stream) |=> (phase_ff == PH_RIFF && idx_ff == '0))
      else $error("parser not reset after end of stream");

endmodule
